/* sv/osg_pkg.sv */
package osg_pkg;

    localparam int SAMPLE_W          = 12;
    localparam int THR_W             = 15;
    localparam int HEAD_W            = 16;
    localparam int VEL_W             = 16;
    localparam int PIN_HIST_W        = 7;
    localparam int WINDOW_LENGTH_DEF = 5;

    // Rotation datapath: velocity scaled by 256, plus headroom for the CORDIC gain
    // and a diagonal vector.
    localparam int VEL_SHIFT    = 8;
    localparam int ROT_W        = 26;
    localparam int ANG_W        = 16;
    localparam int CORDIC_STEPS = 14;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    act;  // residual angle nonzero, run the micro-rotations
    } t_rot;

    function automatic logic signed [ANG_W-1:0] atan_lut(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 16'sd8192;
            1:       v = 16'sd4836;
            2:       v = 16'sd2555;
            3:       v = 16'sd1297;
            4:       v = 16'sd651;
            5:       v = 16'sd326;
            6:       v = 16'sd163;
            7:       v = 16'sd81;
            8:       v = 16'sd41;
            9:       v = 16'sd20;
            10:      v = 16'sd10;
            11:      v = 16'sd5;
            12:      v = 16'sd3;
            13:      v = 16'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Negate the heading, take out whole quarter turns and leave a residual
    // angle in [-8192, 8191].
    function automatic t_rot prerotate(input logic [HEAD_W-1:0] heading,
                                       input logic signed [VEL_W-1:0] vx,
                                       input logic signed [VEL_W-1:0] vy);
        logic [ANG_W-1:0]        a;
        logic [ANG_W:0]          a_rnd;
        logic [1:0]              q;
        logic signed [ROT_W-1:0] x0;
        logic signed [ROT_W-1:0] y0;
        t_rot                    r;
        a     = ANG_W'(0) - ANG_W'(heading);
        a_rnd = {1'b0, a} + (ANG_W+1)'(8192);
        q     = a_rnd[15:14];
        x0    = {{(ROT_W-VEL_W-VEL_SHIFT){vx[VEL_W-1]}}, vx, {VEL_SHIFT{1'b0}}};
        y0    = {{(ROT_W-VEL_W-VEL_SHIFT){vy[VEL_W-1]}}, vy, {VEL_SHIFT{1'b0}}};
        r.z   = $signed(a - {q, 14'b0});
        r.act = (r.z != '0);
        case (q)
            2'd0: begin
                r.x = x0;
                r.y = y0;
            end
            2'd1: begin
                r.x = -y0;
                r.y = x0;
            end
            2'd2: begin
                r.x = -x0;
                r.y = -y0;
            end
            default: begin
                r.x = y0;
                r.y = -x0;
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/obstacle_stop_guard.sv */
// Obstacle stop guard for an omnidirectional base.
//
// Slave stream: one transfer per sensor tick carries three raw 12-bit range
// samples, two obstacle pins (0 = obstacle), the heading and the global
// velocity command. Master stream: one transfer per tick carries the stop
// flag, the three moving-window sums and the two pin path-clear flags.
// Configuration: i_cfg_wr_en writes the collision threshold (sum of the
// window, at or below means obstacle); write it only while the block is idle.
//
// From input transfer to output valid a tick passes the input register, two
// CORDIC stage registers and the result register. It takes one tick per cycle
// while the receiver accepts; the 5-, 5- and 4-step CORDIC segments between
// registers set the clock period. Window and pin histories advance as a tick
// leaves the input register, so ticks keep their order.
//
// Reset clears the histories, the running sums, the threshold and all stage
// valid bits. When the receiver stalls, the result register holds, stages
// behind it fill up and o_s_axis_tready falls once every stage is full.
module obstacle_stop_guard
    import osg_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_wr_en,
    input  logic [14:0]  i_cfg_wr_data,
    // slave side
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // sample_a[11:0], sample_b[23:12], sample_c[35:24], pin_a[36], pin_b[37],
    // heading[53:38], vel_x[69:54], vel_y[85:70], zero fill [87:86]
    input  logic [87:0]  i_s_axis_tdata,
    // master side
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // stop_motion[0], sum_a[15:1], sum_b[30:16], sum_c[45:31],
    // clear_a[46], clear_b[47]
    output logic [47:0]  o_m_axis_tdata
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    // per-tick results that ride alongside the rotation
    typedef struct packed {
        logic [THR_W-1:0] sum_a;
        logic [THR_W-1:0] sum_b;
        logic [THR_W-1:0] sum_c;
        logic             le_a;
        logic             le_b;
        logic             le_c;
        logic             clear_a;
        logic             clear_b;
    } t_side;

    logic [THR_W-1:0]      r_threshold;
    logic [87:0]           r_s1_data;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic                  r_out_valid;
    logic [47:0]           r_out_data;
    t_rot                  r_rot2;
    t_rot                  r_rot3;
    t_side                 r_side2;
    t_side                 r_side3;
    logic [PIN_HIST_W-1:0] r_pin_hist_a;
    logic [PIN_HIST_W-1:0] r_pin_hist_b;

    t_rot                  n_rot1;
    t_rot                  n_rot2;
    t_rot                  n_rot3;
    t_rot                  n_rot4;
    t_side                 n_side2;
    logic                  n_stop;
    logic [47:0]           n_out_data;

    logic                  ld1;
    logic                  ld2;
    logic                  ld3;
    logic                  ld4;
    logic                  win_en;
    logic [SUM_W-1:0]      sum_a;
    logic [SUM_W-1:0]      sum_b;
    logic [SUM_W-1:0]      sum_c;
    logic                  pos_x;
    logic                  pos_y;
    logic                  neg_y;

    // A stage loads when it is empty or its contents move on.
    assign ld4 = !r_out_valid || i_m_axis_tready;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign o_s_axis_tready = ld1;
    assign win_en = r_v1 && ld2;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Stage 1 -> 2: filters and the first CORDIC segment.
    osg_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_win_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (win_en),
        .i_sample (r_s1_data[11:0]),
        .o_sum    (sum_a)
    );

    osg_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_win_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (win_en),
        .i_sample (r_s1_data[23:12]),
        .o_sum    (sum_b)
    );

    osg_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_win_c (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (win_en),
        .i_sample (r_s1_data[35:24]),
        .o_sum    (sum_c)
    );

    always_comb begin
        n_side2.sum_a   = THR_W'(sum_a);
        n_side2.sum_b   = THR_W'(sum_b);
        n_side2.sum_c   = THR_W'(sum_c);
        // compare at full width, mask only on output
        n_side2.le_a    = CMP_W'(sum_a) <= CMP_W'(r_threshold);
        n_side2.le_b    = CMP_W'(sum_b) <= CMP_W'(r_threshold);
        n_side2.le_c    = CMP_W'(sum_c) <= CMP_W'(r_threshold);
        // path clear when the pin read 1 from three to seven ticks ago
        n_side2.clear_a = &r_pin_hist_a[6:2];
        n_side2.clear_b = &r_pin_hist_b[6:2];
    end

    assign n_rot1 = prerotate(r_s1_data[53:38], $signed(r_s1_data[69:54]),
                              $signed(r_s1_data[85:70]));

    osg_cordic_seg #(.FIRST(0), .COUNT(5)) u_seg0 (
        .i_rot (n_rot1),
        .o_rot (n_rot2)
    );

    osg_cordic_seg #(.FIRST(5), .COUNT(5)) u_seg1 (
        .i_rot (r_rot2),
        .o_rot (n_rot3)
    );

    osg_cordic_seg #(.FIRST(10), .COUNT(CORDIC_STEPS - 10)) u_seg2 (
        .i_rot (r_rot3),
        .o_rot (n_rot4)
    );

    // Stop decision by the quadrant of the robot-frame velocity; the gain is
    // positive so only the signs matter.
    always_comb begin
        pos_x = !n_rot4.x[ROT_W-1] && (n_rot4.x != '0);
        neg_y = n_rot4.y[ROT_W-1];
        pos_y = !n_rot4.y[ROT_W-1] && (n_rot4.y != '0);
        if (pos_x && neg_y) begin
            n_stop = r_side3.le_a || r_side3.le_b || !r_side3.clear_a;
        end else if (!pos_x && !pos_y) begin
            n_stop = r_side3.le_a || !r_side3.clear_a;
        end else if (!pos_x && pos_y) begin
            n_stop = r_side3.le_c || !r_side3.clear_b;
        end else begin
            n_stop = 1'b0;
        end
        n_out_data = {r_side3.clear_b, r_side3.clear_a, r_side3.sum_c,
                      r_side3.sum_b, r_side3.sum_a, n_stop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pin_hist_a <= '0;
            r_pin_hist_b <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            if (ld1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_out_valid <= r_v3;
            end
            // advance pin histories with the analog windows
            if (win_en) begin
                r_pin_hist_a <= {r_pin_hist_a[PIN_HIST_W-2:0], r_s1_data[36]};
                r_pin_hist_b <= {r_pin_hist_b[PIN_HIST_W-2:0], r_s1_data[37]};
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (ld1 && i_s_axis_tvalid) begin
            r_s1_data <= i_s_axis_tdata;
        end
        if (ld2 && r_v1) begin
            r_rot2  <= n_rot2;
            r_side2 <= n_side2;
        end
        if (ld3 && r_v2) begin
            r_rot3  <= n_rot3;
            r_side3 <= r_side2;
        end
        if (ld4 && r_v3) begin
            r_out_data <= n_out_data;
        end
    end

    // An empty result register never blocks the input.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

    // A tick leaving the last CORDIC stage lands in the result register.
    a_stage3_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && ld4) |=> r_out_valid)
        else $error("tick lost between last stage and result register");

    // A blocked input stage keeps its tick.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !ld2) |=> (r_v1 && $stable(r_s1_data)))
        else $error("input stage changed while blocked");

    // Skipped micro-rotations leave the residual angle at zero.
    a_idle_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_rot2.act) |-> (r_rot2.z == '0))
        else $error("inactive rotation with nonzero angle");

endmodule

/* sv/osg_window.sv */
module osg_window
    import osg_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int SUM_W         = SAMPLE_W + $clog2(WINDOW_LENGTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SUM_W-1:0]    o_sum
);

    localparam int HIST_D = WINDOW_LENGTH - 1;

    logic [SAMPLE_W-1:0] r_hist [HIST_D];
    logic [SUM_W-1:0]    r_run;  // sum of the stored history
    logic [SUM_W-1:0]    n_run;

    assign o_sum = r_run + SUM_W'(i_sample);
    // drop the oldest sample, add the new one
    assign n_run = o_sum - SUM_W'(r_hist[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            for (int i = 0; i < HIST_D; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_en) begin
            r_run <= n_run;
            for (int i = 0; i < HIST_D - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HIST_D-1] <= i_sample;
        end
    end

endmodule

/* sv/osg_cordic_seg.sv */
module osg_cordic_seg
    import osg_pkg::*;
#(
    parameter int FIRST = 0,
    parameter int COUNT = 5
) (
    input  t_rot i_rot,
    output t_rot o_rot
);

    t_rot                    v;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;

    always_comb begin
        v  = i_rot;
        dx = '0;
        dy = '0;
        for (int k = 0; k < COUNT; k++) begin
            if (v.act) begin
                dx = v.y >>> (FIRST + k);
                dy = v.x >>> (FIRST + k);
                if (!v.z[ANG_W-1]) begin
                    v.x = v.x - dx;
                    v.y = v.y + dy;
                    v.z = v.z - atan_lut(FIRST + k);
                end else begin
                    v.x = v.x + dx;
                    v.y = v.y - dy;
                    v.z = v.z + atan_lut(FIRST + k);
                end
            end
        end
        o_rot = v;
    end

endmodule
